### rtl/core/lrep_pkg.sv
// Shared constants, codes and interface types of the LR expression evaluator.
package lrep_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int SP_W        = ADDR_W + 1;
   localparam int DATA_W      = 32;

   // token kinds
   localparam logic [2:0] TOK_INT   = 3'd0;
   localparam logic [2:0] TOK_PLUS  = 3'd1;
   localparam logic [2:0] TOK_TIMES = 3'd2;
   localparam logic [2:0] TOK_OPEN  = 3'd3;
   localparam logic [2:0] TOK_CLOSE = 3'd4;
   localparam logic [2:0] TOK_END   = 3'd5;

   // result status
   localparam logic [1:0] STAT_PENDING  = 2'd0;
   localparam logic [1:0] STAT_ACCEPT   = 2'd1;
   localparam logic [1:0] STAT_SYNTAX   = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   // reduction kinds, one per reducing LR state
   localparam logic [1:0] RED_INT   = 2'd0;   // E -> int
   localparam logic [1:0] RED_ADD   = 2'd1;   // E -> E + E
   localparam logic [1:0] RED_MUL   = 2'd2;   // E -> E * E
   localparam logic [1:0] RED_PAREN = 2'd3;   // E -> ( E )

   typedef struct packed {
      logic       latch;        // capture the incoming word
      logic       shift;        // push a terminal
      logic [3:0] shift_state;
      logic       shift_int;    // pushed value is the token value
      logic       reduce;       // perform one reduction
      logic [1:0] kind;
      logic       load_rsp;     // load the output register
      logic       clear;        // empty both stacks
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [3:0] top_state;
      logic [2:0] tok;
      logic       full;
      logic       red_ok;
   } stat_type;

endpackage

### rtl/core/lrep_dpath.sv
// Datapath: state and value stacks, top-of-stack registers, evaluator, output register.
module lrep_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [2:0]                    req_cmd,
   input  logic [lrep_pkg::DATA_W-1:0]   req_int_value,
   input  lrep_pkg::cmd_type             cmd,
   output lrep_pkg::stat_type            stat,
   output logic [1:0]                    rsp_status,
   output logic [lrep_pkg::DATA_W-1:0]   rsp_result_value
);
   import lrep_pkg::*;

   logic [3:0]        state_mem [STACK_DEPTH];
   logic [DATA_W-1:0] value_mem [STACK_DEPTH];

   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [3:0]        top_state_ff, top_state_in;
   logic [DATA_W-1:0] top_val_ff, top_val_in;
   logic [2:0]        tok_ff;
   logic [DATA_W-1:0] tok_val_ff;
   logic [3:0]        rd_state_ff;
   logic [DATA_W-1:0] rd_val_ff;
   logic [1:0]        rsp_status_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   logic [SP_W-1:0]   red_n;
   logic [SP_W-1:0]   new_sp;
   logic [ADDR_W-1:0] state_raddr, val_raddr;
   logic [3:0]        below_state;
   logic [3:0]        goto_state;
   logic              goto_ok;
   logic [DATA_W-1:0] red_value;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [3:0]        wr_state;
   logic [DATA_W-1:0] wr_value;

   assign red_n  = (cmd.kind == RED_INT) ? SP_W'(1) : SP_W'(3);
   assign new_sp = sp_ff - red_n;

   // read addresses: state below the popped symbols, value of the left operand or of the bracketed E
   always_comb begin
      state_raddr = ADDR_W'(new_sp - SP_W'(1));
      if (cmd.kind == RED_PAREN)
         val_raddr = ADDR_W'(sp_ff - SP_W'(2));
      else
         val_raddr = ADDR_W'(sp_ff - SP_W'(3));
   end

   assign below_state = (new_sp == '0) ? 4'd0 : rd_state_ff;

   always_comb begin
      goto_ok = 1'b1;
      unique case (below_state)
         4'd0:    goto_state = 4'd1;
         4'd2:    goto_state = 4'd6;
         4'd4:    goto_state = 4'd7;
         4'd5:    goto_state = 4'd8;
         default: begin
            goto_state = 4'd0;
            goto_ok    = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (cmd.kind)
         RED_INT:   red_value = top_val_ff;
         RED_ADD:   red_value = rd_val_ff + top_val_ff;
         RED_MUL:   red_value = DATA_W'(rd_val_ff * top_val_ff);
         default:   red_value = rd_val_ff;
      endcase
   end

   assign stat.top_state = top_state_ff;
   assign stat.tok       = tok_ff;
   assign stat.full      = (sp_ff >= SP_W'(STACK_DEPTH));
   assign stat.red_ok    = (sp_ff >= red_n) && goto_ok;

   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = sp_ff[ADDR_W-1:0];
      wr_state     = cmd.shift_state;
      wr_value     = cmd.shift_int ? tok_val_ff : '0;
      sp_in        = sp_ff;
      top_state_in = top_state_ff;
      top_val_in   = top_val_ff;
      if (cmd.clear) begin
         sp_in        = '0;
         top_state_in = 4'd0;
      end else if (cmd.shift) begin
         wr_en        = 1'b1;
         sp_in        = sp_ff + SP_W'(1);
         top_state_in = wr_state;
         top_val_in   = wr_value;
      end else if (cmd.reduce && stat.red_ok) begin
         wr_en        = 1'b1;
         wr_addr      = new_sp[ADDR_W-1:0];
         wr_state     = goto_state;
         wr_value     = red_value;
         sp_in        = new_sp + SP_W'(1);
         top_state_in = goto_state;
         top_val_in   = red_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         top_state_ff <= 4'd0;
      end else begin
         sp_ff        <= sp_in;
         top_state_ff <= top_state_in;
      end
   end

   always_ff @(posedge clock) begin
      top_val_ff <= top_val_in;
      if (cmd.latch) begin
         tok_ff     <= req_cmd;
         tok_val_ff <= req_int_value;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.status;
         rsp_value_ff  <= (cmd.status == STAT_ACCEPT) ? top_val_ff : '0;
      end
   end

   // stack memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_state;
         value_mem[wr_addr] <= wr_value;
      end
      rd_state_ff <= state_mem[state_raddr];
      rd_val_ff   <= value_mem[val_raddr];
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

### rtl/core/lrep_ctrl.sv
// Controller: LR action decode and sequencing of shifts, reductions and results.
module lrep_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  lrep_pkg::stat_type stat,
   output lrep_pkg::cmd_type  cmd
);
   import lrep_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_REDUCE = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   localparam logic [1:0] ACT_ERROR  = 2'd0;
   localparam logic [1:0] ACT_SHIFT  = 2'd1;
   localparam logic [1:0] ACT_REDUCE = 2'd2;
   localparam logic [1:0] ACT_ACCEPT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] act;
   logic [3:0] shift_state;
   logic       opnd;
   logic [1:0] kind;
   logic       out_free;

   assign opnd = (stat.tok == TOK_PLUS) || (stat.tok == TOK_TIMES) ||
                 (stat.tok == TOK_CLOSE) || (stat.tok == TOK_END);

   // LR action table
   always_comb begin
      act         = ACT_ERROR;
      shift_state = 4'd0;
      unique case (stat.top_state) inside
         4'd0, 4'd2, 4'd4, 4'd5: begin
            if (stat.tok == TOK_INT) begin
               act         = ACT_SHIFT;
               shift_state = 4'd3;
            end else if (stat.tok == TOK_OPEN) begin
               act         = ACT_SHIFT;
               shift_state = 4'd2;
            end
         end
         4'd1: begin
            if (stat.tok == TOK_PLUS) begin
               act         = ACT_SHIFT;
               shift_state = 4'd4;
            end else if (stat.tok == TOK_TIMES) begin
               act         = ACT_SHIFT;
               shift_state = 4'd5;
            end else if (stat.tok == TOK_END) begin
               act = ACT_ACCEPT;
            end
         end
         4'd6: begin
            if (stat.tok == TOK_CLOSE) begin
               act         = ACT_SHIFT;
               shift_state = 4'd9;
            end else if (stat.tok == TOK_PLUS) begin
               act         = ACT_SHIFT;
               shift_state = 4'd4;
            end else if (stat.tok == TOK_TIMES) begin
               act         = ACT_SHIFT;
               shift_state = 4'd5;
            end
         end
         4'd7: begin
            if (stat.tok == TOK_TIMES) begin
               act         = ACT_SHIFT;
               shift_state = 4'd5;
            end else if (opnd) begin
               act = ACT_REDUCE;
            end
         end
         4'd3, 4'd8, 4'd9: begin
            if (opnd)
               act = ACT_REDUCE;
         end
         default: act = ACT_ERROR;
      endcase
   end

   always_comb begin
      unique case (stat.top_state)
         4'd3:    kind = RED_INT;
         4'd7:    kind = RED_ADD;
         4'd8:    kind = RED_MUL;
         default: kind = RED_PAREN;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      status_in        = status_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      cmd              = '0;
      cmd.kind         = kind;
      cmd.shift_state  = shift_state;
      cmd.shift_int    = (stat.tok == TOK_INT);
      cmd.status       = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (act)
               ACT_SHIFT: begin
                  if (stat.full) begin
                     status_in = STAT_OVERFLOW;
                  end else begin
                     cmd.shift = 1'b1;
                     status_in = STAT_PENDING;
                  end
                  state_in = S_DONE;
               end
               ACT_REDUCE: state_in = S_REDUCE;
               ACT_ACCEPT: begin
                  status_in = STAT_ACCEPT;
                  state_in  = S_DONE;
               end
               default: begin
                  status_in = STAT_SYNTAX;
                  state_in  = S_DONE;
               end
            endcase
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            if (stat.red_ok) begin
               state_in = S_DECIDE;
            end else begin
               status_in = STAT_SYNTAX;
               state_in  = S_DONE;
            end
         end
         default: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.clear    = (status_ff != STAT_PENDING);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STAT_PENDING;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/lr_expression_parser_evaluator.sv
// Top level of the LR arithmetic expression parser and evaluator.
// Each token passes IDLE, DECIDE and DONE, plus a REDUCE and a DECIDE for each of the
// reductions the token triggers; each reduction is one stack read plus one write.
// A new word is taken only back in IDLE, also while the last result still waits.
// Reset (synchronous, active high) empties the stacks and drops any pending result;
// stack memory contents are left as they are and never read before being written.
module lr_expression_parser_evaluator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_cmd,
   input  logic signed [lrep_pkg::DATA_W-1:0]   req_int_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic signed [lrep_pkg::DATA_W-1:0]   rsp_result_value
);
   import lrep_pkg::*;

   // controller to datapath commands, datapath to controller flags
   cmd_type           cmd;
   stat_type          stat;
   logic [DATA_W-1:0] int_value;
   logic [DATA_W-1:0] result_value;

   assign int_value        = req_int_value;
   assign rsp_result_value = result_value;

   // controller: IDLE takes a word, DECIDE looks up the LR action for the top
   // state and token, REDUCE pops and pushes the goto state, DONE posts the result
   lrep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: stack memories, top-of-stack registers, add/multiply, output word
   lrep_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_int_value    (int_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_result_value (result_value)
   );

endmodule
